### sv/skcg_pkg.sv
// Shared types and constants for the soft-knee compressor gain core.
package skcg_pkg;

  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 24;

  localparam logic [CFG_INDEX_W-1:0] REG_THRESHOLD = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SLOPE     = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_MAKEUP    = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_ATTACK    = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_RELEASE   = 3'd4;

  localparam logic signed [13:0] THRESHOLD_RST = -14'sd640;
  localparam logic signed [15:0] SLOPE_RST     = -16'sd24576;
  localparam logic signed [11:0] MAKEUP_RST    = 12'sd192;
  localparam logic [23:0]        ATTACK_RST    = 24'd16742300;
  localparam logic [23:0]        RELEASE_RST   = 24'd16773721;

  localparam logic [22:0]        ENV_MAX         = 23'h7FFFFF;
  localparam logic [23:0]        GAIN_MAX        = 24'hFFFFFF;
  localparam logic [23:0]        GAIN_RST        = 24'd1048576;
  localparam logic [24:0]        ONE_Q24         = 25'h1000000;
  localparam logic signed [15:0] DB_FLOOR        = -16'sd15360;
  localparam logic signed [26:0] DB_PER_LOG2_Q16 = 27'sd25252226;
  localparam logic signed [26:0] LOG2_PER_DB_Q8  = 27'sd11146541;
  localparam logic signed [17:0] KNEE_HALF       = 18'sd64;

  typedef struct packed {
    logic signed [13:0] thresh;
    logic signed [15:0] slope;
    logic signed [11:0] makeup;
    logic [23:0]        attack_coefficient;
    logic [23:0]        release_coefficient;
  } cfg_t;

  typedef enum logic [4:0] {
    OP_NOP, OP_LOAD, OP_ENV_MUL, OP_ENV_UPD, OP_NORM, OP_FLOOR,
    OP_LFRAC_MUL, OP_LFRAC_SPLIT, OP_LRD1, OP_LDIFF_MUL, OP_LSUM,
    OP_LCONV_MUL, OP_LEVEL, OP_OVER, OP_GR_ZERO, OP_GR_LIN_MUL, OP_GR_LIN,
    OP_KK_MUL, OP_KK_SL_MUL, OP_GR_KNEE, OP_DB_MUL, OP_LOG2, OP_TGT_MAX,
    OP_TGT_ZERO, OP_EFRAC_MUL, OP_EFRAC_SPLIT, OP_ERD1, OP_EDIFF_MUL,
    OP_ESUM, OP_ESCALE, OP_GAIN_MUL, OP_GAIN_UPD
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic env_zero;
    logic norm_msb;
    logic over_lo;
    logic over_hi;
    logic n_hi;
    logic n_lo;
  } status_t;

endpackage

### sv/skcg_dp.sv
// Datapath: envelope, log/exp table interpolation, knee curve and gain smoothing.
module skcg_dp #(
  parameter int unsigned LOG_TABLE_ENTRIES = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  skcg_pkg::cmd_t      cmd,
  input  skcg_pkg::cfg_t      cfg,
  input  logic signed [23:0]  sidechain_sample,
  output skcg_pkg::status_t   status,
  output logic [23:0]         gain_value
);
  import skcg_pkg::*;

  localparam int unsigned IW = $clog2(LOG_TABLE_ENTRIES + 1);

  typedef logic [31:0] tab_t [LOG_TABLE_ENTRIES+1];

  function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
    logic [63:0] v, res, bit_w;
    v = v_in;
    res = '0;
    bit_w = 64'd1 << 62;
    for (int j = 0; j < 32; j++) begin
      if (bit_w > v) bit_w = bit_w >> 2;
    end
    for (int j = 0; j < 32; j++) begin
      if (bit_w != 0) begin
        if (v >= res + bit_w) begin
          v = v - (res + bit_w);
          res = (res >> 1) + bit_w;
        end else begin
          res = res >> 1;
        end
        bit_w = bit_w >> 2;
      end
    end
    return res;
  endfunction

  function automatic tab_t build_log();
    tab_t t;
    logic [63:0] y;
    logic [31:0] r;
    for (int i = 0; i < LOG_TABLE_ENTRIES; i++) begin
      y = (64'd1 << 30) + ((64'(i) << 30) / LOG_TABLE_ENTRIES);
      r = '0;
      for (int k = 0; k < 24; k++) begin
        y = (y * y) >> 30;
        if (y >= (64'd1 << 31)) begin
          y = y >> 1;
          r[23-k] = 1'b1;
        end
      end
      t[i] = r;
    end
    t[LOG_TABLE_ENTRIES] = 32'h0100_0000;
    return t;
  endfunction

  function automatic tab_t build_exp();
    tab_t t;
    logic [63:0] roots [25];
    logic [63:0] tf, e;
    roots[0] = 64'd1 << 31;
    for (int k = 1; k <= 24; k++) roots[k] = isqrt64(roots[k-1] << 30);
    for (int i = 0; i < LOG_TABLE_ENTRIES; i++) begin
      tf = (64'(i) << 24) / LOG_TABLE_ENTRIES;
      e = 64'd1 << 30;
      for (int k = 1; k <= 24; k++) begin
        if (tf[24-k]) e = (e * roots[k] + (64'd1 << 29)) >> 30;
      end
      t[i] = e[31:0];
    end
    t[LOG_TABLE_ENTRIES] = 32'h8000_0000;
    return t;
  endfunction

  localparam tab_t LOG_TAB = build_log();
  localparam tab_t EXP_TAB = build_exp();

  function automatic logic signed [58:0] shr_round(input logic signed [58:0] v,
                                                  input int unsigned s);
    logic [58:0] mag, r;
    mag = v[58] ? 59'(-v) : 59'(v);
    r = (mag + (59'd1 << (s - 1))) >> s;
    return v[58] ? -$signed(r) : $signed(r);
  endfunction

  logic [22:0]        x, env, norm;
  logic [4:0]         p;
  logic [23:0]        gain, target, rem;
  logic [IW-1:0]      idx, rom_addr;
  logic               rom_sel;
  logic [31:0]        rom_data, base, ev;
  logic signed [31:0] lacc, l;
  logic signed [15:0] level;
  logic signed [17:0] over, gr, over_c, k, db;
  logic signed [31:0] mul_a;
  logic signed [26:0] mul_b;
  logic signed [58:0] prod, pole_rnd;
  logic [23:0]        mag24, c_env, c_gain;
  logic signed [24:0] env_diff, g_diff;
  logic signed [7:0]  n;
  logic [4:0]         sh;
  logic [32:0]        g33;
  logic signed [5:0]  pexp;

  assign mag24    = sidechain_sample[23] ? 24'(-sidechain_sample) : 24'(sidechain_sample);
  assign env_diff = $signed({2'b0, x}) - $signed({2'b0, env});
  assign g_diff   = $signed({1'b0, target}) - $signed({1'b0, gain});
  assign c_env    = (x > env) ? cfg.attack_coefficient : cfg.release_coefficient;
  assign c_gain   = (target < gain) ? cfg.attack_coefficient : cfg.release_coefficient;
  assign pole_rnd = (prod + 59'sd8388608) >>> 24;
  assign over_c   = 18'(level) - 18'(cfg.thresh);
  assign k        = over + KNEE_HALF;
  assign db       = gr + 18'(cfg.makeup);
  assign n        = $signed(l[31:24]);
  assign sh       = 5'(8'sd10 - n);
  assign g33      = ({1'b0, ev} + (33'd1 << (sh - 5'd1))) >> sh;
  assign pexp     = $signed({1'b0, p}) - 6'sd20;

  assign status.env_zero = (env == '0);
  assign status.norm_msb = norm[22];
  assign status.over_lo  = (over_c <= -KNEE_HALF);
  assign status.over_hi  = (over_c >= KNEE_HALF);
  assign status.n_hi     = (n >= 8'sd4);
  assign status.n_lo     = (n < -8'sd21);

  always_comb begin
    mul_a    = '0;
    mul_b    = '0;
    rom_addr = idx;
    rom_sel  = 1'b0;
    case (cmd.op)
      OP_ENV_MUL: begin
        mul_a = 32'(env_diff);
        mul_b = $signed({2'b0, ONE_Q24 - {1'b0, c_env}});
      end
      OP_LFRAC_MUL: begin
        mul_a = $signed({10'b0, norm[21:0]});
        mul_b = 27'(LOG_TABLE_ENTRIES);
      end
      OP_LFRAC_SPLIT: rom_addr = prod[22 +: IW];
      OP_LRD1: rom_addr = idx + IW'(1);
      OP_LDIFF_MUL: begin
        mul_a = $signed(rom_data - base);
        mul_b = $signed({3'b0, rem});
      end
      OP_LCONV_MUL: begin
        mul_a = lacc;
        mul_b = DB_PER_LOG2_Q16;
      end
      OP_GR_LIN_MUL: begin
        mul_a = 32'(over);
        mul_b = 27'(cfg.slope);
      end
      OP_KK_MUL: begin
        mul_a = 32'(k);
        mul_b = 27'(k);
      end
      OP_KK_SL_MUL: begin
        mul_a = $signed({18'b0, prod[13:0]});
        mul_b = 27'(cfg.slope);
      end
      OP_DB_MUL: begin
        mul_a = 32'(db);
        mul_b = LOG2_PER_DB_Q8;
      end
      OP_EFRAC_MUL: begin
        mul_a = $signed({8'b0, l[23:0]});
        mul_b = 27'(LOG_TABLE_ENTRIES);
      end
      OP_EFRAC_SPLIT: begin
        rom_addr = prod[24 +: IW];
        rom_sel  = 1'b1;
      end
      OP_ERD1: begin
        rom_addr = idx + IW'(1);
        rom_sel  = 1'b1;
      end
      OP_EDIFF_MUL: begin
        mul_a   = $signed(rom_data - base);
        mul_b   = $signed({3'b0, rem});
        rom_sel = 1'b1;
      end
      OP_GAIN_MUL: begin
        mul_a = 32'(g_diff);
        mul_b = $signed({2'b0, ONE_Q24 - {1'b0, c_gain}});
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    prod     <= mul_a * mul_b;
    rom_data <= rom_sel ? EXP_TAB[rom_addr] : LOG_TAB[rom_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      env  <= '0;
      gain <= GAIN_RST;
    end else begin
      case (cmd.op)
        OP_LOAD: x <= mag24[23] ? ENV_MAX : mag24[22:0];
        OP_ENV_UPD: begin
          env  <= env + pole_rnd[22:0];
          norm <= env + pole_rnd[22:0];
          p    <= 5'd22;
        end
        OP_NORM: begin
          if (!norm[22]) begin
            norm <= {norm[21:0], 1'b0};
            p    <= p - 5'd1;
          end
        end
        OP_FLOOR: level <= DB_FLOOR;
        OP_LFRAC_SPLIT: begin
          idx <= prod[22 +: IW];
          rem <= {2'b0, prod[21:0]};
        end
        OP_LRD1, OP_ERD1: base <= rom_data;
        OP_LSUM: lacc <= 32'($signed({pexp, 24'h0})) + $signed(base)
                         + $signed(prod[53:22]);
        OP_LEVEL: level <= 16'(shr_round(prod, 40));
        OP_OVER: over <= over_c;
        OP_GR_ZERO: gr <= '0;
        OP_GR_LIN: gr <= 18'(shr_round(prod, 15));
        OP_GR_KNEE: gr <= 18'(shr_round(prod, 23));
        OP_LOG2: l <= 32'(shr_round(prod, 8));
        OP_TGT_MAX: target <= GAIN_MAX;
        OP_TGT_ZERO: target <= '0;
        OP_EFRAC_SPLIT: begin
          idx <= prod[24 +: IW];
          rem <= prod[23:0];
        end
        OP_ESUM: ev <= base + prod[55:24];
        OP_ESCALE: target <= (g33 > 33'(GAIN_MAX)) ? GAIN_MAX : g33[23:0];
        OP_GAIN_UPD: begin
          gain       <= gain + pole_rnd[23:0];
          gain_value <= gain + pole_rnd[23:0];
        end
        default: ;
      endcase
    end
  end

endmodule

### sv/skcg_ctrl.sv
// Controller: sequences the datapath through one item and runs the handshakes.
module skcg_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  skcg_pkg::status_t   status,
  output skcg_pkg::cmd_t      cmd
);
  import skcg_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_ENV_MUL, S_ENV_UPD, S_NORM, S_FLOOR, S_LFRAC_MUL, S_LFRAC_SPLIT,
    S_LRD1, S_LDIFF_MUL, S_LSUM, S_LCONV_MUL, S_LEVEL, S_OVER, S_GR_ZERO,
    S_GR_LIN_MUL, S_GR_LIN, S_KK_MUL, S_KK_SL_MUL, S_GR_KNEE, S_DB_MUL,
    S_LOG2, S_ESEL, S_TGT_MAX, S_TGT_ZERO, S_EFRAC_MUL, S_EFRAC_SPLIT,
    S_ERD1, S_EDIFF_MUL, S_ESUM, S_ESCALE, S_GAIN_MUL, S_GAIN_UPD
  } state_t;

  state_t state, state_next;
  logic   slot_free;

  assign in_ready  = (state == S_IDLE);
  assign slot_free = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    cmd.op     = OP_NOP;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op     = OP_LOAD;
          state_next = S_ENV_MUL;
        end
      end
      S_ENV_MUL: begin
        cmd.op = OP_ENV_MUL;
        state_next = S_ENV_UPD;
      end
      S_ENV_UPD: begin
        cmd.op = OP_ENV_UPD;
        state_next = S_NORM;
      end
      S_NORM: begin
        cmd.op = OP_NORM;
        if (status.env_zero) state_next = S_FLOOR;
        else if (status.norm_msb) state_next = S_LFRAC_MUL;
      end
      S_FLOOR: begin
        cmd.op = OP_FLOOR;
        state_next = S_OVER;
      end
      S_LFRAC_MUL: begin
        cmd.op = OP_LFRAC_MUL;
        state_next = S_LFRAC_SPLIT;
      end
      S_LFRAC_SPLIT: begin
        cmd.op = OP_LFRAC_SPLIT;
        state_next = S_LRD1;
      end
      S_LRD1: begin
        cmd.op = OP_LRD1;
        state_next = S_LDIFF_MUL;
      end
      S_LDIFF_MUL: begin
        cmd.op = OP_LDIFF_MUL;
        state_next = S_LSUM;
      end
      S_LSUM: begin
        cmd.op = OP_LSUM;
        state_next = S_LCONV_MUL;
      end
      S_LCONV_MUL: begin
        cmd.op = OP_LCONV_MUL;
        state_next = S_LEVEL;
      end
      S_LEVEL: begin
        cmd.op = OP_LEVEL;
        state_next = S_OVER;
      end
      S_OVER: begin
        cmd.op = OP_OVER;
        if (status.over_lo) state_next = S_GR_ZERO;
        else if (status.over_hi) state_next = S_GR_LIN_MUL;
        else state_next = S_KK_MUL;
      end
      S_GR_ZERO: begin
        cmd.op = OP_GR_ZERO;
        state_next = S_DB_MUL;
      end
      S_GR_LIN_MUL: begin
        cmd.op = OP_GR_LIN_MUL;
        state_next = S_GR_LIN;
      end
      S_GR_LIN: begin
        cmd.op = OP_GR_LIN;
        state_next = S_DB_MUL;
      end
      S_KK_MUL: begin
        cmd.op = OP_KK_MUL;
        state_next = S_KK_SL_MUL;
      end
      S_KK_SL_MUL: begin
        cmd.op = OP_KK_SL_MUL;
        state_next = S_GR_KNEE;
      end
      S_GR_KNEE: begin
        cmd.op = OP_GR_KNEE;
        state_next = S_DB_MUL;
      end
      S_DB_MUL: begin
        cmd.op = OP_DB_MUL;
        state_next = S_LOG2;
      end
      S_LOG2: begin
        cmd.op = OP_LOG2;
        state_next = S_ESEL;
      end
      S_ESEL: begin
        if (status.n_hi) state_next = S_TGT_MAX;
        else if (status.n_lo) state_next = S_TGT_ZERO;
        else state_next = S_EFRAC_MUL;
      end
      S_TGT_MAX: begin
        cmd.op = OP_TGT_MAX;
        state_next = S_GAIN_MUL;
      end
      S_TGT_ZERO: begin
        cmd.op = OP_TGT_ZERO;
        state_next = S_GAIN_MUL;
      end
      S_EFRAC_MUL: begin
        cmd.op = OP_EFRAC_MUL;
        state_next = S_EFRAC_SPLIT;
      end
      S_EFRAC_SPLIT: begin
        cmd.op = OP_EFRAC_SPLIT;
        state_next = S_ERD1;
      end
      S_ERD1: begin
        cmd.op = OP_ERD1;
        state_next = S_EDIFF_MUL;
      end
      S_EDIFF_MUL: begin
        cmd.op = OP_EDIFF_MUL;
        state_next = S_ESUM;
      end
      S_ESUM: begin
        cmd.op = OP_ESUM;
        state_next = S_ESCALE;
      end
      S_ESCALE: begin
        cmd.op = OP_ESCALE;
        state_next = S_GAIN_MUL;
      end
      S_GAIN_MUL: begin
        cmd.op = OP_GAIN_MUL;
        if (slot_free) state_next = S_GAIN_UPD;
      end
      S_GAIN_UPD: begin
        cmd.op = OP_GAIN_UPD;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_GAIN_UPD) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

endmodule

### sv/soft_knee_compressor_gain_core.sv
// Soft-knee compressor gain core: one sidechain sample in, one smoothed Q4.20
// gain out per item. An item waits before its gain update until the previous
// result has been taken. The envelope's leading-one search shifts one bit per
// cycle, and every product goes through one shared 32x27 multiplier in turn.
// The finished gain sits in an output register, so the next item is taken
// while it waits. Log and exp tables are constant ROMs of LOG_TABLE_ENTRIES+1
// words each; no clearing pass is needed after reset.
module soft_knee_compressor_gain_core #(
  parameter int unsigned LOG_TABLE_ENTRIES = 64
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [23:0]                 sidechain_sample,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [23:0]                        gain_value,
  input  logic                               cfg_write,
  input  logic [skcg_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [skcg_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import skcg_pkg::*;

  cfg_t    cfg;
  cmd_t    cmd;
  status_t status;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.thresh              <= THRESHOLD_RST;
      cfg.slope               <= SLOPE_RST;
      cfg.makeup              <= MAKEUP_RST;
      cfg.attack_coefficient  <= ATTACK_RST;
      cfg.release_coefficient <= RELEASE_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_THRESHOLD: cfg.thresh              <= $signed(cfg_data[13:0]);
        REG_SLOPE:     cfg.slope               <= $signed(cfg_data[15:0]);
        REG_MAKEUP:    cfg.makeup              <= $signed(cfg_data[11:0]);
        REG_ATTACK:    cfg.attack_coefficient  <= cfg_data;
        REG_RELEASE:   cfg.release_coefficient <= cfg_data;
        default: ;
      endcase
    end
  end

  skcg_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  skcg_dp #(
    .LOG_TABLE_ENTRIES (LOG_TABLE_ENTRIES)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .cfg              (cfg),
    .sidechain_sample (sidechain_sample),
    .status           (status),
    .gain_value       (gain_value)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("accepted a second item back to back");

  a_result_from_update: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(cmd.op == OP_GAIN_UPD))
    else $error("result shown without a gain update");

  a_no_accept_during_update: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_GAIN_UPD) |-> !in_ready)
    else $error("input ready while gain update in progress");

endmodule

### tb/sv/tb.sv
// Self-checking testbench for the soft-knee compressor gain core.
class gain_scoreboard;
  localparam longint unsigned TAB_N = 64;
  longint unsigned log_tab[TAB_N+1];
  longint unsigned exp_tab[TAB_N+1];
  logic [13:0] thresh;
  logic [15:0] slope;
  logic [11:0] makeup;
  logic [23:0] attack_coef;
  logic [23:0] release_coef;
  logic [22:0] envelope;
  logic [23:0] gain_state;
  logic [23:0] expected_gain[$];
  int errors;

  function new();
    build_tables();
    thresh = skcg_pkg::THRESHOLD_RST;
    slope = skcg_pkg::SLOPE_RST;
    makeup = skcg_pkg::MAKEUP_RST;
    attack_coef = skcg_pkg::ATTACK_RST;
    release_coef = skcg_pkg::RELEASE_RST;
    envelope = '0;
    gain_state = skcg_pkg::GAIN_RST;
    errors = 0;
  endfunction

  function longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function void build_tables();
    longint unsigned roots[25];
    longint unsigned y, t, e;
    logic [31:0] r;
    for (int k = 0; k <= 24; k++)
      roots[k] = (k == 0) ? (64'd1 << 31) : int_sqrt(roots[k-1] << 30);
    for (int i = 0; i < TAB_N; i++) begin
      y = (64'd1 << 30) + ((longint'(i) << 30) / TAB_N);
      t = (longint'(i) << 24) / TAB_N;
      e = 64'd1 << 30;
      r = 0;
      for (int k = 0; k < 24; k++) begin
        y = (y * y) >> 30;
        if (y >= (64'd1 << 31)) begin
          y >>= 1;
          r[23-k] = 1'b1;
        end
      end
      log_tab[i] = r;
      for (int k = 1; k <= 24; k++)
        if (t[24-k]) e = (e * roots[k] + (64'd1 << 29)) >> 30;
      exp_tab[i] = e;
    end
    log_tab[TAB_N] = 64'd1 << 24;
    exp_tab[TAB_N] = 64'd1 << 31;
  endfunction

  function longint round_shift(longint v, int s);
    longint half;
    half = longint'(64'd1 << (s - 1));
    if (v >= 0) return (v + half) >>> s;
    return -((-v + half) >>> s);
  endfunction

  function logic [23:0] one_pole(logic [23:0] c, longint unsigned prev, longint unsigned x);
    longint unsigned sum;
    sum = longint'(c) * prev + ((64'd1 << 24) - c) * x + (64'd1 << 23);
    return sum[47:24];
  endfunction

  function longint env_level(logic [22:0] env);
    longint p, l;
    longint unsigned frac, scaled, rem, lg, idx;
    if (env == 0) return skcg_pkg::DB_FLOOR;
    p = 0;
    while (p < 22 && (env >> (p + 1)) != 0) p++;
    frac = (longint'(env) << (22 - p)) - (64'd1 << 22);
    scaled = frac * TAB_N;
    idx = scaled >> 22;
    rem = scaled & ((64'd1 << 22) - 1);
    lg = log_tab[idx] + (((log_tab[idx+1] - log_tab[idx]) * rem) >> 22);
    l = (p - 20) * longint'(64'd1 << 24) + longint'(lg);
    return round_shift(l * 25252226, 40);
  endfunction

  function logic [23:0] linear_gain(longint db);
    longint l, n, f;
    longint unsigned scaled, rem, e, g, idx, sh;
    l = round_shift(db * 11146541, 8);
    if (l >= 0) n = l >>> 24;
    else n = -((-l + (64'd1 << 24) - 1) >>> 24);
    if (n >= 4) return skcg_pkg::GAIN_MAX;
    if (n < -21) return '0;
    f = l - n * longint'(64'd1 << 24);
    scaled = longint'(f) * TAB_N;
    idx = scaled >> 24;
    rem = scaled & ((64'd1 << 24) - 1);
    e = exp_tab[idx] + (((exp_tab[idx+1] - exp_tab[idx]) * rem) >> 24);
    sh = 10 - n;
    g = (e + (64'd1 << (sh - 1))) >> sh;
    return (g > 64'hFFFFFF) ? skcg_pkg::GAIN_MAX : g[23:0];
  endfunction

  function void write_reg(logic [2:0] idx, logic [23:0] data);
    case (idx)
      skcg_pkg::REG_THRESHOLD: thresh = data[13:0];
      skcg_pkg::REG_SLOPE:     slope = data[15:0];
      skcg_pkg::REG_MAKEUP:    makeup = data[11:0];
      skcg_pkg::REG_ATTACK:    attack_coef = data;
      skcg_pkg::REG_RELEASE:   release_coef = data;
      default: ;
    endcase
  endfunction

  function void note_sample(logic [23:0] sample);
    longint s, mag, level, over, gr, sl, k;
    logic [22:0] x;
    logic [23:0] target;
    s = $signed(sample);
    mag = (s < 0) ? -s : s;
    x = (mag > 8388607) ? skcg_pkg::ENV_MAX : mag[22:0];
    if (x > envelope) envelope = one_pole(attack_coef, envelope, x);
    else envelope = one_pole(release_coef, envelope, x);
    level = env_level(envelope);
    over = level - longint'($signed(thresh));
    sl = $signed(slope);
    if (over <= -64) gr = 0;
    else if (over >= 64) gr = round_shift(sl * over, 15);
    else begin
      k = over + 64;
      gr = round_shift(sl * k * k, 23);
    end
    target = linear_gain(gr + longint'($signed(makeup)));
    if (target < gain_state) gain_state = one_pole(attack_coef, gain_state, target);
    else gain_state = one_pole(release_coef, gain_state, target);
    expected_gain.push_back(gain_state);
  endfunction

  function void check_gain(logic [23:0] actual);
    logic [23:0] exp_g;
    if (expected_gain.size() == 0) begin
      $error("gain_value unexpected item, actual %0d", actual);
      errors++;
      return;
    end
    exp_g = expected_gain.pop_front();
    if (actual !== exp_g) begin
      $error("gain_value expected %0d actual %0d", exp_g, actual);
      errors++;
    end
  endfunction
endclass

module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import skcg_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SETTLE = 80;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [23:0] sidechain_sample = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [23:0] gain_value;
  logic cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;
  int quiet_cycles = 0;
  gain_scoreboard sb = new();

  always #4 clk = ~clk;

  soft_knee_compressor_gain_core u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .sidechain_sample(sidechain_sample),
    .out_valid(out_valid), .out_ready(out_ready), .gain_value(gain_value),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= receiver_stall_pct);
    if (!rst && in_valid && in_ready) sb.note_sample(sidechain_sample);
    if (!rst && out_valid && out_ready) sb.check_gain(gain_value);
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic push_sample(input logic [23:0] s);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    sidechain_sample <= s;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.expected_gain.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [23:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    sb.write_reg(idx, data);
    cfg_write <= 1'b0;
  endtask

  task automatic load_settings(input logic [23:0] thr, input logic [23:0] slp,
                               input logic [23:0] mk, input logic [23:0] att,
                               input logic [23:0] rel);
    drain();
    write_reg(REG_THRESHOLD, thr);
    write_reg(REG_SLOPE, slp);
    write_reg(REG_MAKEUP, mk);
    write_reg(REG_ATTACK, att);
    write_reg(REG_RELEASE, rel);
    write_reg(3'd5 + 3'($urandom_range(2)), 24'($urandom()));
  endtask

  function automatic logic [23:0] random_sample();
    logic [23:0] v;
    v = 24'($urandom());
    case ($urandom_range(9))
      0: return 24'h800000;
      1: return 24'h7FFFFF;
      2: return '0;
      3, 4: return 24'($signed(v) >>> $urandom_range(23));
      default: return v;
    endcase
  endfunction

  function automatic logic [23:0] random_coef();
    case ($urandom_range(3))
      0: return 24'($urandom_range(255));
      1: return 24'hFFFFFF - 24'($urandom_range(65535));
      default: return 24'($urandom());
    endcase
  endfunction

  task automatic random_items(input int count);
    for (int k = 0; k < count; k++) begin
      case ((k / 25) % 5)
        1: begin sender_idle_pct = 72; receiver_stall_pct = 0; end
        2: begin sender_idle_pct = 0; receiver_stall_pct = 72; end
        3: begin sender_idle_pct = 37; receiver_stall_pct = 37; end
        default: begin sender_idle_pct = 0; receiver_stall_pct = 0; end
      endcase
      push_sample(random_sample());
    end
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
  endtask

  initial begin
    logic [23:0] directed[$];
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    directed = '{24'h000000, 24'h7FFFFF, 24'h800000, 24'hFFFFFF, 24'h000001,
                 24'h400000, 24'hC00000, 24'h000000, 24'h100000, 24'h555555,
                 24'hAAAAAA};
    foreach (directed[i]) push_sample(directed[i]);
    // fast poles, deep threshold, full-ratio limiting slope and extreme makeup
    load_settings(-24'sd7680, -24'sd32768, 24'sd1536, 24'd0, 24'd0);
    foreach (directed[i]) push_sample(directed[i]);
    load_settings(24'd0, 24'h7FFF, 24'h7FF, 24'hFFFFFF, 24'hFFFFFF);
    push_sample(24'h7FFFFF);
    push_sample(24'h000010);
    load_settings(-24'sd7680, -24'sd32768, -24'sd2048, 24'd100, 24'd4000);
    push_sample(24'h7FFFFF);
    push_sample(24'h800000);

    load_settings(-24'sd640, -24'sd24576, 24'sd192, 24'd16000000, 24'd16700000);
    random_items(100);
    load_settings(24'd0, 24'd0, 24'd0, random_coef(), random_coef());
    random_items(100);
    for (int ph = 0; ph < 5; ph++) begin
      load_settings(-24'($urandom_range(7680)), -24'($urandom_range(32768)),
                    24'($signed(12'($urandom_range(3072))) - 12'sd1536),
                    random_coef(), random_coef());
      random_items(100);
    end
    load_settings(24'($urandom()), 24'($urandom()), 24'($urandom()),
                  random_coef(), random_coef());
    random_items(100);

    drain();
    if (sb.errors == 0 && sb.expected_gain.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
